// ===== src/tpcl_pkg.sv =====
// Package: shared types, register indexes and constants of the thermal PID current limiter
package tpcl_pkg;

  localparam logic [14:0] ONE_Q14 = 15'd16384;

  localparam logic [14:0] RST_ACTIVATION_THRESHOLD = 15'd1638;
  localparam logic [15:0] RST_TARGET_TEMPERATURE   = 16'd15360;
  localparam logic [14:0] RST_INTEGRAL_LIMIT       = 15'd2560;
  localparam logic [15:0] RST_SAMPLE_PERIOD        = 16'd6554;
  localparam logic [15:0] RST_SAMPLE_RATE          = 16'd2560;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVATION_THRESHOLD = 3'd0,
    CFG_TARGET_TEMPERATURE   = 3'd1,
    CFG_INTEGRAL_LIMIT       = 3'd2,
    CFG_GAIN_PROPORTIONAL    = 3'd3,
    CFG_GAIN_INTEGRAL        = 3'd4,
    CFG_GAIN_DERIVATIVE      = 3'd5,
    CFG_SAMPLE_PERIOD        = 3'd6,
    CFG_SAMPLE_RATE          = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic        [14:0] activation_threshold;
    logic signed [15:0] target_temperature;
    logic        [14:0] integral_limit;
    logic signed [15:0] gain_proportional;
    logic signed [15:0] gain_integral;
    logic signed [15:0] gain_derivative;
    logic        [15:0] sample_period;
    logic        [15:0] sample_rate;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] emitter_temperature;
    logic        [14:0] drive_level;
    logic        [14:0] level_ceiling;
    logic        [14:0] battery_limit;
  } in_item_t;

  typedef struct packed {
    logic [14:0] new_ceiling;
    logic        loop_active;
  } out_item_t;

  typedef enum logic [2:0] {
    MUL_NONE       = 3'd0,
    MUL_E_PERIOD   = 3'd1,
    MUL_KP_E       = 3'd2,
    MUL_KI_INTEG   = 3'd3,
    MUL_NUM_RATE   = 3'd4,
    MUL_KD_NR      = 3'd5,
    MUL_CEIL_FACT  = 3'd6
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD  = 2'd0,
    ACC_LOAD9 = 2'd1,
    ACC_ADD9  = 2'd2,
    ACC_ADD   = 2'd3
  } acc_op_t;

  typedef struct packed {
    logic    load_in;
    mul_op_t mul_op;
    logic    integ_upd;
    acc_op_t acc_op;
    logic    fact_load;
    logic    lim_load;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic start_active;
    logic out_free;
  } status_t;

endpackage

// ===== src/tpcl_chan_if.sv =====
// Interface: valid/ready channel carrying one payload item per transfer
interface tpcl_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/tpcl_cfg_regs.sv =====
// Configuration register file written through the plain write port
module tpcl_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tpcl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpcl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output tpcl_pkg::cfg_t                      cfg
);
  import tpcl_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ACTIVATION_THRESHOLD: cfg_nxt.activation_threshold = cfg_wdata[14:0];
        CFG_TARGET_TEMPERATURE:   cfg_nxt.target_temperature   = signed'(cfg_wdata);
        CFG_INTEGRAL_LIMIT:       cfg_nxt.integral_limit       = cfg_wdata[14:0];
        CFG_GAIN_PROPORTIONAL:    cfg_nxt.gain_proportional    = signed'(cfg_wdata);
        CFG_GAIN_INTEGRAL:        cfg_nxt.gain_integral        = signed'(cfg_wdata);
        CFG_GAIN_DERIVATIVE:      cfg_nxt.gain_derivative      = signed'(cfg_wdata);
        CFG_SAMPLE_PERIOD:        cfg_nxt.sample_period        = cfg_wdata;
        CFG_SAMPLE_RATE:          cfg_nxt.sample_rate          = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.activation_threshold <= RST_ACTIVATION_THRESHOLD;
      cfg_r.target_temperature   <= signed'(RST_TARGET_TEMPERATURE);
      cfg_r.integral_limit       <= RST_INTEGRAL_LIMIT;
      cfg_r.gain_proportional    <= '0;
      cfg_r.gain_integral        <= '0;
      cfg_r.gain_derivative      <= '0;
      cfg_r.sample_period        <= RST_SAMPLE_PERIOD;
      cfg_r.sample_rate          <= RST_SAMPLE_RATE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/tpcl_ctrl.sv =====
// Controller: sequences one control tick through the shared multiplier
module tpcl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tpcl_pkg::status_t status,
  output tpcl_pkg::cmd_t    cmd
);
  import tpcl_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_INT   = 11'b000_0000_0010,
    ST_CLAMP = 11'b000_0000_0100,
    ST_P     = 11'b000_0000_1000,
    ST_I     = 11'b000_0001_0000,
    ST_N     = 11'b000_0010_0000,
    ST_D     = 11'b000_0100_0000,
    ST_F     = 11'b000_1000_0000,
    ST_C     = 11'b001_0000_0000,
    ST_LIM   = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load_in   = 1'b0;
    cmd.mul_op    = MUL_NONE;
    cmd.integ_upd = 1'b0;
    cmd.acc_op    = ACC_HOLD;
    cmd.fact_load = 1'b0;
    cmd.lim_load  = 1'b0;
    cmd.out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = status.start_active ? ST_INT : ST_DONE;
        end
      end
      ST_INT: begin
        cmd.mul_op = MUL_E_PERIOD;
        state_nxt  = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_op    = MUL_KP_E;
        state_nxt     = ST_P;
      end
      ST_P: begin
        cmd.acc_op = ACC_LOAD9;
        cmd.mul_op = MUL_KI_INTEG;
        state_nxt  = ST_I;
      end
      ST_I: begin
        cmd.acc_op = ACC_ADD9;
        cmd.mul_op = MUL_NUM_RATE;
        state_nxt  = ST_N;
      end
      ST_N: begin
        cmd.mul_op = MUL_KD_NR;
        state_nxt  = ST_D;
      end
      ST_D: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_F;
      end
      ST_F: begin
        cmd.fact_load = 1'b1;
        state_nxt     = ST_C;
      end
      ST_C: begin
        cmd.mul_op = MUL_CEIL_FACT;
        state_nxt  = ST_LIM;
      end
      ST_LIM: begin
        cmd.lim_load = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/tpcl_dpath.sv =====
// Datapath: error history, clamped integral, PID accumulator, shared multiplier, result register
module tpcl_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  tpcl_pkg::cfg_t     cfg,
  input  tpcl_pkg::in_item_t in_item,
  input  tpcl_pkg::cmd_t     cmd,
  output tpcl_pkg::status_t  status,
  tpcl_chan_if.source        out_chan
);
  import tpcl_pkg::*;

  logic signed [16:0] e_r;
  logic        [14:0] ceiling_r;
  logic        [14:0] battery_r;
  logic        [14:0] thermal_r;
  logic               active_r;

  logic signed [16:0] error_integral_r;
  logic signed [16:0] last_error_r;
  logic signed [16:0] error_before_last_r;
  logic        [1:0]  history_count_r;

  logic signed [62:0] prod_r;
  logic signed [55:0] acc_r;
  logic signed [55:0] acc_nxt;
  logic        [44:0] factor_r;

  logic               out_valid_r;
  out_item_t          out_item_r;

  logic signed [45:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [62:0] mul_p;

  logic signed [20:0] num;
  logic signed [62:0] step_full;
  logic signed [18:0] integ_sum;
  logic signed [18:0] integ_lim;
  logic signed [18:0] integ_clamped;
  logic signed [56:0] fact_full;
  logic signed [62:0] lim_full;
  logic        [14:0] thermal_nxt;
  logic signed [16:0] e_in;

  assign e_in = 17'(cfg.target_temperature) - 17'(in_item.emitter_temperature);

  always_comb begin
    unique case (history_count_r)
      2'd0:    num = '0;
      2'd1:    num = (21'(e_r) - 21'(last_error_r)) <<< 1;
      default: num = 21'(e_r) + (21'(e_r) <<< 1) - (21'(last_error_r) <<< 2)
                     + 21'(error_before_last_r);
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      MUL_E_PERIOD: begin
        mul_a = 46'(e_r);
        mul_b = signed'({1'b0, cfg.sample_period});
      end
      MUL_KP_E: begin
        mul_a = 46'(e_r);
        mul_b = 17'(cfg.gain_proportional);
      end
      MUL_KI_INTEG: begin
        mul_a = 46'(error_integral_r);
        mul_b = 17'(cfg.gain_integral);
      end
      MUL_NUM_RATE: begin
        mul_a = 46'(num);
        mul_b = signed'({1'b0, cfg.sample_rate});
      end
      MUL_KD_NR: begin
        mul_a = 46'(signed'(prod_r[37:0]));
        mul_b = 17'(cfg.gain_derivative);
      end
      MUL_CEIL_FACT: begin
        mul_a = signed'({1'b0, factor_r});
        mul_b = signed'({2'b00, ceiling_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign step_full     = (prod_r + 63'sd32768) >>> 16;
  assign integ_sum     = 19'(error_integral_r) + signed'(step_full[18:0]);
  assign integ_lim     = signed'({4'b0000, cfg.integral_limit});

  always_comb begin
    priority if (integ_sum > integ_lim) begin
      integ_clamped = integ_lim;
    end else if (integ_sum < -integ_lim) begin
      integ_clamped = -integ_lim;
    end else begin
      integ_clamped = integ_sum;
    end
  end

  always_comb begin
    unique case (cmd.acc_op)
      ACC_LOAD9: acc_nxt = signed'({prod_r[46:0], 9'b0});
      ACC_ADD9:  acc_nxt = acc_r + signed'({prod_r[46:0], 9'b0});
      ACC_ADD:   acc_nxt = acc_r + signed'(prod_r[55:0]);
      default:   acc_nxt = acc_r;
    endcase
  end

  assign fact_full = 57'sd536870912 + 57'(acc_r);
  assign lim_full  = (prod_r + 63'sd268435456) >>> 29;

  always_comb begin
    if (lim_full > 63'sd16384) begin
      thermal_nxt = ONE_Q14;
    end else begin
      thermal_nxt = lim_full[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      e_r       <= e_in;
      ceiling_r <= in_item.level_ceiling;
      battery_r <= in_item.battery_limit;
      active_r  <= status.start_active;
      thermal_r <= ONE_Q14;
    end
    if (cmd.lim_load) begin
      thermal_r <= thermal_nxt;
    end
    if (cmd.mul_op != MUL_NONE) begin
      prod_r <= mul_p;
    end
    acc_r <= acc_nxt;
    if (cmd.fact_load) begin
      priority if (fact_full <= 57'sd0) begin
        factor_r <= '0;
      end else if (fact_full > 57'sd17592186044416) begin
        factor_r <= 45'h1000_0000_0000;
      end else begin
        factor_r <= fact_full[44:0];
      end
    end
    if (cmd.out_load) begin
      out_item_r.new_ceiling <= (battery_r < thermal_r) ? battery_r : thermal_r;
      out_item_r.loop_active <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_integral_r    <= '0;
      last_error_r        <= '0;
      error_before_last_r <= '0;
      history_count_r     <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      if (cmd.integ_upd) begin
        error_integral_r <= integ_clamped[16:0];
      end
      if (cmd.lim_load) begin
        error_before_last_r <= last_error_r;
        last_error_r        <= e_r;
        if (history_count_r != 2'd2) begin
          history_count_r <= history_count_r + 2'd1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.start_active = in_item.drive_level > cfg.activation_threshold;
  assign status.out_free     = !out_valid_r || out_chan.ready;

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;

endmodule

// ===== src/thermal_pid_current_limiter_unit.sv =====
// Top level: thermal PID current limiter with configuration registers, controller and datapath
// One item is taken at a time. When drive_level is above the activation threshold the tick
// runs the PID loop from transfer in to the result being loaded, and the unit is ready
// again on the next cycle; otherwise the tick skips the loop and goes straight to loading
// the result. The loop runs through the single 46x17 signed multiplier, used six times
// in sequence per tick (integral step, P, I, derivative numerator times rate, D gain,
// ceiling times factor), each product registered before use. A finished result sits in
// an output register, so the next item is taken while it waits; a new result waits in the
// last step only if the previous one has not been transferred yet. Configuration is
// written through cfg_we/cfg_index/cfg_wdata and must only change while no tick is in
// flight.
module thermal_pid_current_limiter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  tpcl_chan_if.sink                           in_chan,
  tpcl_chan_if.source                         out_chan,
  input  logic                                cfg_we,
  input  logic [tpcl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpcl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tpcl_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  tpcl_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tpcl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tpcl_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_item  (in_chan.payload),
    .cmd      (cmd),
    .status   (status),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input taken again straight after a transfer");

  a_ceiling_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.payload.new_ceiling <= ONE_Q14)
    else $error("new ceiling above full level");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result register overwritten before transfer");
`endif

endmodule
